FILE: hw/rtl/ppe_pkg.sv
package ppe_pkg;

  // input vector layout
  localparam int COMP_W   = 16;
  localparam int NUM_COMP = 3;
  localparam int SEP_W    = COMP_W * NUM_COMP;

  // square root datapath
  localparam int RAD_W  = 2 * COMP_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // distance in Q.16, wide enough for the smallest coordinate fraction
  localparam int V_FRAC = 16;
  localparam int R_W    = ROOT_W + 8;
  localparam int BND_W  = R_W + 2;
  localparam int MAG_W  = 16;

  // shared multiplier of the evaluator
  localparam int MULA_W = 32;
  localparam int MULB_W = 19;
  localparam int PROD_W = MULA_W + MULB_W;

  // potential values and terms
  localparam int V_W     = V_FRAC + 1;
  localparam int T_W     = V_W + 5;
  localparam int TMAG_W  = T_W - 1;
  localparam int SCALE_W = 16;
  localparam int SUM_W   = 32;
  localparam int TERM_W  = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  localparam int SHIFT_CENTER = 9;
  localparam int SHIFT_PATCH  = 8;

  // item kinds
  localparam logic CMD_CENTER = 1'b0;
  localparam logic CMD_PATCH  = 1'b1;

  // shape constants in Q.16, the a coefficients are plain integers
  localparam int C_DS_CORE = 55706;
  localparam int C_DC_WIDE = 77101;
  localparam int C_X0_ISO  = 26214;
  localparam int C_DS_ATT  = 6554;
  localparam int C_DC_ATT  = 32768;
  localparam int C_B_WIDE  = 170630;
  localparam int C_B_ATT   = 327680;
  localparam int C_A_WIDE  = 1;
  localparam int C_A_ATT   = 20;

  typedef enum logic [1:0] {
    SH_REP,
    SH_ISO,
    SH_ATT
  } shape_t;

  typedef enum logic [1:0] {
    RG_NONE,
    RG_CORE,
    RG_SHLO,
    RG_SHHI
  } region_t;

  typedef struct packed {
    logic signed [BND_W-1:0] x0;
    logic signed [BND_W-1:0] ds;
    logic signed [BND_W-1:0] dc;
    logic [MULB_W-1:0]       a;
    logic [MULB_W-1:0]       b;
  } shape_par_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic               start;
    logic               cmd;
    logic [R_W-1:0]     r;
    logic [SCALE_W-1:0] scale;
  } eval_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TERM_W-1:0] term;
  } eval_rsp_t;

  function automatic shape_par_t shape_par(shape_t s);
    shape_par_t p;
    unique case (s)
      SH_ISO: begin
        p.x0 = BND_W'(C_X0_ISO);
        p.ds = BND_W'(C_DS_CORE);
        p.dc = BND_W'(C_DC_WIDE);
        p.a  = MULB_W'(C_A_WIDE);
        p.b  = MULB_W'(C_B_WIDE);
      end
      SH_ATT: begin
        p.x0 = BND_W'(0);
        p.ds = BND_W'(C_DS_ATT);
        p.dc = BND_W'(C_DC_ATT);
        p.a  = MULB_W'(C_A_ATT);
        p.b  = MULB_W'(C_B_ATT);
      end
      default: begin
        p.x0 = BND_W'(0);
        p.ds = BND_W'(C_DS_CORE);
        p.dc = BND_W'(C_DC_WIDE);
        p.a  = MULB_W'(C_A_WIDE);
        p.b  = MULB_W'(C_B_WIDE);
      end
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/ppe_sqrt.sv
module ppe_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  ppe_pkg::sqrt_req_t req,
  output ppe_pkg::sqrt_rsp_t rsp
);
  import ppe_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad_sr;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic              done;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // two radicand bits in, one root bit out per cycle
  assign rem_sh = {rem[ROOT_W-1:0], rad_sr[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    done <= !rst && !req.start && busy && (cnt == CNT_W'(ROOT_W - 1));
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      cnt    <= '0;
      rad_sr <= req.rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sr <= rad_sr << 2;
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

FILE: hw/rtl/ppe_eval.sv
module ppe_eval (
  input  logic              clk,
  input  logic              rst,
  input  ppe_pkg::eval_req_t req,
  output ppe_pkg::eval_rsp_t rsp
);
  import ppe_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE,
    E_SQ,
    E_CO,
    E_VAL,
    E_SC,
    E_RND
  } state_t;

  localparam logic [V_W-1:0] V_ONE = V_W'(1) << V_FRAC;

  state_t                   state;
  shape_t                   shape_q;
  region_t                  region_q;
  logic [R_W-1:0]           r_q;
  logic [PROD_W-1:0]        prod;
  logic [V_W-1:0]           vrep;
  logic [TMAG_W-1:0]        tmag;
  logic                     tneg;
  logic                     shift9;
  logic                     done;
  logic signed [TERM_W-1:0] term;

  shape_par_t              par;
  logic signed [BND_W-1:0] rs;
  logic signed [BND_W-1:0] lo_core, hi_core, lo_sh, hi_sh;
  logic signed [BND_W-1:0] ref_pt, diff, absd;
  region_t                 region;
  logic [MAG_W-1:0]        mag;
  logic [MULA_W-1:0]       mul_a;
  logic [MULB_W-1:0]       mul_b;
  logic [PROD_W:0]         core_sum, sh_sum, rnd;
  logic [V_W-1:0]          v;
  logic signed [T_W-1:0]   tsum;
  logic [PROD_W:0]         q;
  logic [TERM_W-2:0]       qv;

  // region of the current shape, all bounds strict
  always_comb begin
    par     = shape_par(shape_q);
    rs      = signed'(BND_W'(r_q));
    lo_core = par.x0 - par.ds;
    hi_core = par.x0 + par.ds;
    lo_sh   = par.x0 - par.dc;
    hi_sh   = par.x0 + par.dc;
    if (rs > lo_core && rs < hi_core) begin
      region = RG_CORE;
      ref_pt = par.x0;
    end else if (rs > lo_sh && rs < lo_core) begin
      region = RG_SHLO;
      ref_pt = lo_sh;
    end else if (rs > hi_core && rs < hi_sh) begin
      region = RG_SHHI;
      ref_pt = hi_sh;
    end else begin
      region = RG_NONE;
      ref_pt = rs;
    end
    diff = rs - ref_pt;
    absd = diff[BND_W-1] ? -diff : diff;
    mag  = absd[MAG_W-1:0];
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      E_SQ: begin
        mul_a = MULA_W'(mag);
        mul_b = MULB_W'(mag);
      end
      E_CO: begin
        mul_a = prod[MULA_W-1:0];
        mul_b = (region_q == RG_CORE) ? par.a : par.b;
      end
      E_SC: begin
        mul_a = MULA_W'(tmag);
        mul_b = MULB_W'(req.scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shape value from coefficient times square, center sum and rounded term
  always_comb begin
    core_sum = {1'b0, prod} + ((PROD_W+1)'(1) << (V_FRAC - 1));
    sh_sum   = {1'b0, prod} + ((PROD_W+1)'(1) << (2*V_FRAC - 1));
    case (region_q)
      RG_CORE:          v = V_ONE - core_sum[V_FRAC +: V_W];
      RG_SHLO, RG_SHHI: v = sh_sum[2*V_FRAC +: V_W];
      default:          v = '0;
    endcase
    tsum = signed'(T_W'({vrep, 3'b000})) + signed'(T_W'({vrep, 1'b0}))
           - signed'(T_W'(v));
    rnd  = {1'b0, prod} + (shift9 ? ((PROD_W+1)'(1) << (SHIFT_CENTER - 1))
                                  : ((PROD_W+1)'(1) << (SHIFT_PATCH - 1)));
    q    = shift9 ? (rnd >> SHIFT_CENTER) : (rnd >> SHIFT_PATCH);
    qv   = q[TERM_W-2:0];
  end

  always_ff @(posedge clk) begin
    done <= !rst && (state == E_RND);
    if (state != E_IDLE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (rst) begin
      state <= E_IDLE;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (req.start) begin
            r_q     <= req.r;
            shape_q <= (req.cmd == CMD_PATCH) ? SH_ATT : SH_REP;
            state   <= E_SQ;
          end
        end
        E_SQ: begin
          region_q <= region;
          state    <= E_CO;
        end
        E_CO: begin
          state <= E_VAL;
        end
        E_VAL: begin
          unique case (shape_q)
            SH_REP: begin
              vrep    <= v;
              shape_q <= SH_ISO;
              state   <= E_SQ;
            end
            SH_ISO: begin
              tneg   <= tsum[T_W-1];
              tmag   <= tsum[T_W-1] ? TMAG_W'(-tsum) : TMAG_W'(tsum);
              shift9 <= 1'b1;
              state  <= E_SC;
            end
            default: begin
              tneg   <= (v != '0);
              tmag   <= TMAG_W'(v);
              shift9 <= 1'b0;
              state  <= E_SC;
            end
          endcase
        end
        E_SC: begin
          state <= E_RND;
        end
        E_RND: begin
          term  <= tneg ? -signed'({1'b0, qv}) : signed'({1'b0, qv});
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.term = term;

endmodule

FILE: hw/rtl/patchy_pair_energy_core.sv
// Pair energy of a patchy particle model. Each input transaction carries one
// separation vector (Q4.12 by default, COORD_FRAC_BITS fraction bits) and a
// kind bit in tuser: center (0) adds scale*(5*Vrep - 0.5*Viso), patch (1) adds
// -scale*Vatt, where each V is a piecewise quadratic well of the distance r
// with strict region bounds. energy_scale (unsigned Q8.8, reset 1.0) is
// written through cfg_we/cfg_wdata; the user must write it only while the
// core is idle, the core itself does not enforce this. The running total
// saturates to the signed 32-bit range on every addition; the transaction
// with tlast set emits the total (signed Q16.16) and clears it. Each vector
// goes through these steps before the next one can be taken: acceptance,
// summing the squared components on one 16x16 multiplier, loading the root
// unit, the bit-serial square root (one root bit per cycle), handing the
// root over, the evaluator on its shared multiplier, then taking the term
// and accumulating it. A finished total sits in the output register while
// the next vector is already being worked on; only a second total waits
// for it to be taken.
module patchy_pair_energy_core #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: energy_scale
  input  logic                             cfg_we,
  input  logic [ppe_pkg::SCALE_W-1:0]      cfg_wdata,
  // input vectors
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ppe_pkg::SEP_W-1:0]        s_axis_tdata,  // sep_x, sep_y, sep_z
  input  logic                             s_axis_tuser,  // cmd
  input  logic                             s_axis_tlast,  // last
  // pair totals
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ppe_pkg::SUM_W-1:0]        m_axis_tdata   // total_energy
);
  import ppe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_EVAL,
    ST_ACC
  } state_t;

  // root has COORD_FRAC_BITS fraction bits, the evaluator works in Q.16
  localparam int RootShift = V_FRAC - COORD_FRAC_BITS;
  localparam int CompCntW  = $clog2(NUM_COMP);

  localparam logic signed [SUM_W+1:0] SumMax = {3'b000, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W+1:0] SumMin = {3'b111, {(SUM_W-1){1'b0}}};

  state_t                   state;
  logic [SCALE_W-1:0]       scale;
  logic                     cmd_q;
  logic                     last_q;
  logic [SEP_W-1:0]         comp_sr;
  logic [CompCntW-1:0]      comp_cnt;
  logic [RAD_W-1:0]         rad_acc;
  logic                     sqrt_start;
  logic                     eval_start;
  logic [R_W-1:0]           r;
  logic signed [TERM_W-1:0] term_q;
  logic signed [SUM_W-1:0]  energy_sum;
  logic                     out_valid;
  logic [SUM_W-1:0]         out_data;

  logic signed [COMP_W-1:0]   comp;
  logic signed [2*COMP_W-1:0] comp_sq;
  logic signed [SUM_W+1:0]    sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;
  logic                       out_free;

  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  eval_req_t eval_req;
  eval_rsp_t eval_rsp;

  // one component squared per cycle, lowest field first
  assign comp    = signed'(comp_sr[COMP_W-1:0]);
  assign comp_sq = comp * comp;

  // saturating accumulate of the registered term
  always_comb begin
    sum_wide = signed'((SUM_W+2)'(energy_sum)) + signed'((SUM_W+2)'(term_q));
    if (sum_wide > SumMax) begin
      sum_sat = SumMax[SUM_W-1:0];
    end else if (sum_wide < SumMin) begin
      sum_sat = SumMin[SUM_W-1:0];
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  assign sqrt_req.start = sqrt_start;
  assign sqrt_req.rad   = rad_acc;

  ppe_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign eval_req.start = eval_start;
  assign eval_req.cmd   = cmd_q;
  assign eval_req.r     = r;
  assign eval_req.scale = scale;

  ppe_eval u_eval (
    .clk (clk),
    .rst (rst),
    .req (eval_req),
    .rsp (eval_rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // item sequencer, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sqrt_start <= 1'b0;
      eval_start <= 1'b0;
      energy_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      // one-cycle start pulses for the root unit and the evaluator
      sqrt_start <= (state == ST_SQ) && (comp_cnt == CompCntW'(NUM_COMP - 1));
      eval_start <= (state == ST_ROOT) && sqrt_rsp.done;
      if (out_valid && m_axis_tready && !(state == ST_ACC && last_q)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            comp_sr  <= s_axis_tdata;
            cmd_q    <= s_axis_tuser;
            last_q   <= s_axis_tlast;
            rad_acc  <= '0;
            comp_cnt <= '0;
            state    <= ST_SQ;
          end
        end
        ST_SQ: begin
          rad_acc  <= rad_acc + RAD_W'(unsigned'(comp_sq));
          comp_sr  <= comp_sr >> COMP_W;
          comp_cnt <= comp_cnt + CompCntW'(1);
          if (comp_cnt == CompCntW'(NUM_COMP - 1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_rsp.done) begin
            r     <= R_W'(sqrt_rsp.root) << RootShift;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_rsp.done) begin
            term_q <= eval_rsp.term;
            state  <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!last_q) begin
            energy_sum <= sum_sat;
            state      <= ST_IDLE;
          end else if (out_free) begin
            // total goes out, the pair starts from zero
            out_data   <= sum_sat;
            out_valid  <= 1'b1;
            energy_sum <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppe_pkg::SEP_W;
  import ppe_pkg::SUM_W;
  import ppe_pkg::SCALE_W;
  import ppe_pkg::COMP_W;
  import ppe_pkg::CMD_CENTER;
  import ppe_pkg::CMD_PATCH;

  localparam int COORD_FRAC_BITS = 12;
  localparam int CLK_HALF        = 10;
  localparam int LIMIT_CYCLES    = 1000000;
  // wait in cycles for an item with no result to leave the core
  localparam int IDLE_WAIT       = 50;

  // well constants in Q.16
  localparam longint Q16_ONE     = 65536;
  localparam longint Q16_DS_CORE = 55706;
  localparam longint Q16_DC_WIDE = 77101;
  localparam longint Q16_X0_ISO  = 26214;
  localparam longint Q16_DS_ATT  = 6554;
  localparam longint Q16_DC_ATT  = 32768;
  localparam longint Q16_B_WIDE  = 170630;
  localparam longint Q16_B_ATT   = 327680;
  localparam longint TOTAL_MAX   = 64'sd2147483647;
  localparam longint TOTAL_MIN   = -64'sd2147483648;

  // separation vector as it sits in tdata, sep_x in the lowest bits
  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } sep_vec_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [SEP_W-1:0]   s_axis_tdata;   // sep_x, sep_y, sep_z
  logic               s_axis_tuser;   // cmd
  logic               s_axis_tlast;   // last
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SUM_W-1:0]   m_axis_tdata;   // total_energy

  // predictor state
  logic [SCALE_W-1:0]       energy_scale_q88 = SCALE_W'(256);
  longint                   pair_energy_acc = 0;
  logic signed [SUM_W-1:0]  expected_totals[$];
  logic signed [SUM_W-1:0]  popped_total;

  int  error_count = 0;
  int  cycle_count = 0;
  int  rx_stall    = 0;
  bit  steady_flow = 1'b0;

  patchy_pair_energy_core #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // energy predictor
  // ---------------------------------------------------------------------------

  // floor square root, one result bit at a time from the top
  function automatic longint floor_root(longint v);
    longint res;
    longint trial;
    res = 0;
    for (int i = 16; i >= 0; i--) begin
      trial = res | (64'sd1 <<< i);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // piecewise quadratic well, all bounds strict, boundaries give zero
  function automatic longint well_value(longint r, longint a, longint x0, longint ds,
                                        longint b, longint dc);
    longint d;
    longint e;
    if (r > x0 - ds && r < x0 + ds) begin
      d = r - x0;
      return Q16_ONE - ((a * d * d + 64'sd32768) >>> 16);
    end
    if (r > x0 - dc && r < x0 - ds) e = r - (x0 - dc);
    else if (r > x0 + ds && r < x0 + dc) e = r - (x0 + dc);
    else return 0;
    return (b * e * e + (64'sd1 <<< 31)) >>> 32;
  endfunction

  // scaled energy contribution of one separation vector
  function automatic longint pair_term(logic cmd, sep_vec_t v);
    longint sx, sy, sz, r, t, mag, q;
    int     sh;
    sx = v.x;
    sy = v.y;
    sz = v.z;
    r  = floor_root(sx * sx + sy * sy + sz * sz) <<< (16 - COORD_FRAC_BITS);
    if (cmd == CMD_CENTER) begin
      // 10*Vrep - Viso, then divided by 2^9 below
      t  = 10 * well_value(r, 1, 0, Q16_DS_CORE, Q16_B_WIDE, Q16_DC_WIDE)
         - well_value(r, 1, Q16_X0_ISO, Q16_DS_CORE, Q16_B_WIDE, Q16_DC_WIDE);
      sh = 9;
    end else begin
      t  = -well_value(r, 20, 0, Q16_DS_ATT, Q16_B_ATT, Q16_DC_ATT);
      sh = 8;
    end
    // round half away from zero
    mag = (t < 0) ? -t : t;
    q   = (mag * longint'(energy_scale_q88) + (64'sd1 <<< (sh - 1))) >>> sh;
    return (t < 0) ? -q : q;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sep_vec_t sep(int x, int y, int z);
    sep_vec_t v;
    v.x = COMP_W'(x);
    v.y = COMP_W'(y);
    v.z = COMP_W'(z);
    return v;
  endfunction

  // random vector, weighted toward distances where the wells live
  function automatic sep_vec_t random_sep();
    sep_vec_t v;
    int pick, lead, s1, s2;
    pick = $urandom_range(0, 99);
    s1 = 0;
    s2 = 0;
    if (pick < 40) begin
      return sep(int'($urandom_range(0, 7200)) - 3600, int'($urandom_range(0, 7200)) - 3600,
                 int'($urandom_range(0, 7200)) - 3600);
    end else if (pick < 65) begin
      // one dominant axis, small side components
      lead = $urandom_range(0, 7000);
      s1   = int'($urandom_range(0, 600)) - 300;
      s2   = int'($urandom_range(0, 600)) - 300;
    end else if (pick < 85) begin
      // root right at or next to a region bound
      case ($urandom_range(0, 6))
        0: lead = 409;
        1: lead = 410;
        2: lead = 2048;
        3: lead = 3481;
        4: lead = 4819;
        5: lead = 5120;
        default: lead = 6457;
      endcase
      lead = lead + int'($urandom_range(0, 6)) - 3;
    end else begin
      // full range, every bit toggles
      v.x = COMP_W'($urandom);
      v.y = COMP_W'($urandom);
      v.z = COMP_W'($urandom);
      return v;
    end
    if ($urandom_range(0, 1)) lead = -lead;
    case ($urandom_range(0, 2))
      0: return sep(lead, s1, s2);
      1: return sep(s1, lead, s2);
      default: return sep(s1, s2, lead);
    endcase
  endfunction

  // one input transaction; the predictor runs at acceptance
  task automatic send_item(input logic cmd, input sep_vec_t v, input logic last);
    int     gap;
    longint total;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = v;
    s_axis_tuser  = cmd;
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    // saturate on every addition
    total = pair_energy_acc + pair_term(cmd, v);
    if (total > TOTAL_MAX) total = TOTAL_MAX;
    if (total < TOTAL_MIN) total = TOTAL_MIN;
    pair_energy_acc = total;
    if (last) begin
      expected_totals.push_back(SUM_W'(pair_energy_acc));
      pair_energy_acc = 0;
    end
  endtask

  // stop sending and wait for every pending total
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
  endtask

  // register write, only with the core idle
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    drain_results();
    // a non-last item may still be in the datapath
    repeat (IDLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    energy_scale_q88 = value;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // region bounds, zero vector and extremes at the reset scale
  task automatic test_directed_shapes();
    send_item(CMD_CENTER, sep(0, 0, 0), 1'b1);
    send_item(CMD_PATCH,  sep(0, 0, 0), 1'b1);
    // attractive well: core edge near root 409.6, outer bound exactly at 2048
    send_item(CMD_PATCH,  sep(409, 0, 0), 1'b1);
    send_item(CMD_PATCH,  sep(0, -410, 0), 1'b1);
    send_item(CMD_PATCH,  sep(0, 0, 2047), 1'b1);
    send_item(CMD_PATCH,  sep(-2048, 0, 0), 1'b1);
    send_item(CMD_PATCH,  sep(0, 2049, 0), 1'b1);
    // repulsive and isotropic wells; iso core edge falls exactly on root 5120
    send_item(CMD_CENTER, sep(3481, 0, 0), 1'b1);
    send_item(CMD_CENTER, sep(0, 3482, 0), 1'b1);
    send_item(CMD_CENTER, sep(0, 0, -4818), 1'b1);
    send_item(CMD_CENTER, sep(4819, 0, 0), 1'b1);
    send_item(CMD_CENTER, sep(5119, 0, 0), 1'b1);
    send_item(CMD_CENTER, sep(0, -5120, 0), 1'b1);
    send_item(CMD_CENTER, sep(5121, 0, 0), 1'b1);
    send_item(CMD_CENTER, sep(0, 0, 6457), 1'b1);
    send_item(CMD_CENTER, sep(6458, 0, 0), 1'b1);
    // field extremes
    send_item(CMD_CENTER, sep(-32768, -32768, -32768), 1'b1);
    send_item(CMD_PATCH,  sep(32767, 32767, 32767), 1'b1);
    send_item(CMD_PATCH,  sep(-32768, 0, 0), 1'b1);
    // multi-transaction pair mixing both kinds
    send_item(CMD_CENTER, sep(0, 32767, -1), 1'b0);
    send_item(CMD_CENTER, sep(2500, -1200, 300), 1'b0);
    send_item(CMD_PATCH,  sep(0, 1000, 0), 1'b0);
    send_item(CMD_PATCH,  sep(-200, 150, 100), 1'b0);
    send_item(CMD_CENTER, sep(-2000, 1500, 700), 1'b1);
  endtask

  // register extremes and odd values
  task automatic test_scale_extremes();
    logic [SCALE_W-1:0] settings[4];
    settings[0] = SCALE_W'(0);
    settings[1] = SCALE_W'(16'hFFFF);
    settings[2] = SCALE_W'(1);
    settings[3] = SCALE_W'(257);
    for (int k = 0; k < 4; k++) begin
      write_scale(settings[k]);
      send_item(CMD_CENTER, sep(0, 0, 0), 1'b1);
      send_item(CMD_PATCH,  sep(0, 0, 0), 1'b1);
      send_item(CMD_CENTER, sep(4000, 0, 0), 1'b1);
      send_item(CMD_PATCH,  sep(0, 1000, 0), 1'b0);
      send_item(CMD_CENTER, sep(0, 0, 6000), 1'b1);
    end
  endtask

  // accumulator clamps at both ends of the signed range
  task automatic test_saturation();
    write_scale(SCALE_W'(16'hFFFF));
    for (int i = 0; i < 40; i++) send_item(CMD_CENTER, sep(0, 0, 0), i == 39);
    for (int i = 0; i < 140; i++) send_item(CMD_PATCH, sep(0, 0, 0), i == 139);
    // back off from the top after clamping
    for (int i = 0; i < 30; i++) send_item(CMD_CENTER, sep(0, 0, 0), 1'b0);
    send_item(CMD_PATCH, sep(0, 0, 0), 1'b0);
    send_item(CMD_PATCH, sep(100, 0, 0), 1'b1);
  endtask

  // random pairs over several register settings
  task automatic test_random_pairs();
    int   run;
    int   phase_items;
    logic held;
    held = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_scale(SCALE_W'(16'hFFFF));
        4: write_scale(SCALE_W'(1));
        default: write_scale(SCALE_W'($urandom_range(1, 65535)));
      endcase
      // one phase with neither side idling
      steady_flow = (phase == 3);
      phase_items = 0;
      while (phase_items < 125) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        for (int i = 0; i < run; i++)
          send_item(1'($urandom_range(0, 1)), random_sep(), i == run - 1);
        phase_items += run;
        // hold the sender until the core has handed out everything
        if (phase == 2 && !held && phase_items > 80) begin
          drain_results();
          held = 1'b1;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side and checking
  // ---------------------------------------------------------------------------

  // random stalls on the total stream
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      m_axis_tready = 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready = 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 25) rx_stall = pick_gap();
    end
  end

  // compare each total transaction with the oldest pending pair
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        if (error_count < 10)
          $display("total transaction with no pair pending: 0x%08h", m_axis_tdata);
        error_count++;
      end else begin
        popped_total = expected_totals.pop_front();
        if (m_axis_tdata !== popped_total) begin
          if (error_count < 10)
            $display("total_energy mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                     popped_total, popped_total, $signed(m_axis_tdata), m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hang guard
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CENTER;
    s_axis_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_shapes();
    test_scale_extremes();
    test_saturation();
    test_random_pairs();

    drain_results();
    repeat (IDLE_WAIT) @(posedge clk);
    if (error_count == 0 && expected_totals.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppe_pkg.sv
hw/rtl/ppe_sqrt.sv
hw/rtl/ppe_eval.sv
hw/rtl/patchy_pair_energy_core.sv
sim/testbench.sv
